/* src/sprk_pkg.sv */
// ----------------------------------------------------------------------------
// sprk_pkg
// Shared types, codes and helpers of the sparse PageRank engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sprk_pkg;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_RUN   = 2'd1,
    REQ_READ  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    RSP_OK    = 2'd0,
    RSP_FULL  = 2'd1,
    RSP_RANGE = 2'd2,
    RSP_EMPTY = 2'd3
  } rsp_code_t;

  typedef enum logic [1:0] {
    REG_NODE_COUNT     = 2'd0,
    REG_DAMPING        = 2'd1,
    REG_CONV_THRESHOLD = 2'd2,
    REG_ITER_LIMIT     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [10:0] node_count;
    logic [15:0] damping;
    logic [31:0] conv_threshold;
    logic [9:0]  iter_limit;
  } cfg_t;

  localparam logic [15:0] DAMPING_RESET   = 16'd55706;
  localparam logic [31:0] THRESHOLD_RESET = 32'd2147;
  localparam logic [9:0]  MAX_ITER_RESET  = 10'd100;
  localparam logic [31:0] RANK_ONE        = 32'h8000_0000;

  localparam int DIV_W  = 64;
  localparam int DIV_CW = 7;
  localparam logic [DIV_CW-1:0] DIV_STEPS_HALF = 7'd32;
  localparam logic [DIV_CW-1:0] DIV_STEPS_FULL = 7'd64;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLEAR_REQ,
    ST_ADD_INC,
    ST_READ_POST,
    ST_POST_OK,
    ST_SEED_DIV,
    ST_SEED_WR,
    ST_ITER_CHK,
    ST_SINK_RD,
    ST_SINK_ACC,
    ST_SHARE_MUL,
    ST_SHARE_START,
    ST_SHARE_DIV,
    ST_INIT_WR,
    ST_EDGE_START,
    ST_EDGE_RD,
    ST_EDGE_NODE,
    ST_EDGE_CHK,
    ST_EDGE_DIV,
    ST_EDGE_MUL,
    ST_EDGE_ACC,
    ST_EDGE_NEXT,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_NORM_CHK,
    ST_NORM_RD,
    ST_NORM_START,
    ST_NORM_DIV
  } fsm_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_WR,
    OP_CLR_EDGES,
    OP_POST_ERR,
    OP_POST_OK,
    OP_POST_READ,
    OP_ADD_WR,
    OP_ADD_INC,
    OP_READ_RD,
    OP_SEED_START,
    OP_SEED_WR,
    OP_SINK_CLR,
    OP_FINISH,
    OP_SINK_RD,
    OP_SINK_ACC,
    OP_SHARE_MUL,
    OP_SHARE_START,
    OP_INIT_WR,
    OP_EDGE_RD,
    OP_EDGE_NODE,
    OP_EDGE_DIV_START,
    OP_EDGE_MUL,
    OP_EDGE_ACC,
    OP_EDGE_NEXT,
    OP_UPD_RD,
    OP_UPD_WR,
    OP_SUM_RD,
    OP_SUM_ACC,
    OP_NORM_RD,
    OP_NORM_START,
    OP_NORM_WR
  } dp_op_t;

  typedef struct packed {
    req_kind_t kind;
    logic      n_zero;
    logic      node_oor;
    logic      full;
    logic      div_busy;
    logic      idx_last;
    logic      clr_last;
    logic      edge_none;
    logic      edge_last;
    logic      edge_skip;
    logic      iterate;
    logic      sum_zero;
    logic      out_busy;
  } dp_status_t;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    sat32 = (|v[63:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

`default_nettype wire

/* src/sprk_if.sv */
// ----------------------------------------------------------------------------
// sprk_if
// Request and response channels of the sparse PageRank engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface sprk_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [9:0] from_node;
  logic [9:0] to_node;
  modport source(output valid, req_type, from_node, to_node, input ready);
  modport sink(input valid, req_type, from_node, to_node, output ready);
endinterface

interface sprk_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] rank_value;
  logic [9:0]  iterations_used;
  logic        converged;
  modport source(output valid, status, rank_value, iterations_used, converged, input ready);
  modport sink(input valid, status, rank_value, iterations_used, converged, output ready);
endinterface

`default_nettype wire

/* src/sparse_pagerank_power_iteration.sv */
// ----------------------------------------------------------------------------
// sparse_pagerank_power_iteration
// Sparse PageRank engine: edge store, power iteration, normalization.
//
// req carries one request item (add edge, run, read rank, clear edges); rsp
// returns exactly one item per request with status, rank, iteration count and
// convergence flag. Registers sit behind the APB port; the user is to write
// them only while idle, which the block does not enforce. Requests are
// handled one at a time. Clear edges sweeps the degree store. Run: seed
// divide and a write per seed, then per iteration a sink sum, a share
// divide, an accumulator init write, per live edge one 32-step divide and
// an update pass; then a rank sum and one divide per node for normalization.
// The bit-serial divider dominates the run time.
// After reset the degree store is cleared with req.ready low. A stalled rsp
// holds its item and blocks the next request only.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_pagerank_power_iteration #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  sprk_req_if.sink         req,
  sprk_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  sprk_pkg::cfg_t       cfg;
  sprk_pkg::dp_op_t     op;
  sprk_pkg::dp_status_t st;

  assign pready = 1'b1;

  sprk_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
  );

  sprk_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
    .st(st), .op(op)
  );

  sprk_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .op(op), .st(st),
    .req_accept(req.valid && req.ready), .req_type(req.req_type),
    .from_node(req.from_node), .to_node(req.to_node),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.status),
    .rank_value(rsp.rank_value), .iterations_used(rsp.iterations_used),
    .converged(rsp.converged)
  );

endmodule

`default_nettype wire

/* src/sprk_ram.sv */
// ----------------------------------------------------------------------------
// sprk_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sprk_ram #(
  parameter int W = 32,
  parameter int D = 1024
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0]  waddr,
  input  wire logic [W-1:0]                        wdata,
  input  wire logic                                re,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0]  raddr,
  output      logic [W-1:0]                        rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/sprk_div.sv */
// ----------------------------------------------------------------------------
// sprk_div
// Restoring divider, one quotient bit per cycle. The dividend comes
// left-aligned; the quotient ends in the low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sprk_div #(
  parameter int DVW = 43
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [sprk_pkg::DIV_W-1:0]        dividend,
  input  wire logic [DVW-1:0]                    divisor,
  input  wire logic [sprk_pkg::DIV_CW-1:0]       steps,
  output      logic                              busy,
  output      logic [sprk_pkg::DIV_W-1:0]        quotient
);

  logic [DVW-1:0]               rem;
  logic [DVW-1:0]               dvs;
  logic [sprk_pkg::DIV_CW-1:0]  count;
  logic [DVW:0]                 rem_sh;
  logic                         fits;

  always_comb begin
    rem_sh = {rem, quotient[sprk_pkg::DIV_W-1]};
    fits   = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= steps;
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DVW'(rem_sh - {1'b0, dvs}) : DVW'(rem_sh);
      quotient <= {quotient[sprk_pkg::DIV_W-2:0], fits};
      count    <= count - 1'b1;
      if (count == 1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* src/sprk_cfg.sv */
// ----------------------------------------------------------------------------
// sprk_cfg
// APB register file holding the run configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module sprk_cfg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output      logic [31:0]          prdata,
  output      sprk_pkg::cfg_t       cfg
);

  sprk_pkg::reg_idx_t idx;

  assign idx = sprk_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count     <= '0;
      cfg.damping        <= sprk_pkg::DAMPING_RESET;
      cfg.conv_threshold <= sprk_pkg::THRESHOLD_RESET;
      cfg.iter_limit     <= sprk_pkg::MAX_ITER_RESET;
    end else if (psel && penable && pwrite) begin
      case (idx)
        sprk_pkg::REG_NODE_COUNT:     cfg.node_count     <= pwdata[10:0];
        sprk_pkg::REG_DAMPING:        cfg.damping        <= pwdata[15:0];
        sprk_pkg::REG_CONV_THRESHOLD: cfg.conv_threshold <= pwdata;
        sprk_pkg::REG_ITER_LIMIT:     cfg.iter_limit     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      sprk_pkg::REG_NODE_COUNT:     prdata = {21'd0, cfg.node_count};
      sprk_pkg::REG_DAMPING:        prdata = {16'd0, cfg.damping};
      sprk_pkg::REG_CONV_THRESHOLD: prdata = cfg.conv_threshold;
      sprk_pkg::REG_ITER_LIMIT:     prdata = {22'd0, cfg.iter_limit};
      default:                      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* src/sprk_ctrl.sv */
// ----------------------------------------------------------------------------
// sprk_ctrl
// Sequencer: request dispatch, power iteration loop and normalization.
// ----------------------------------------------------------------------------
`default_nettype none

module sprk_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output      logic                 req_ready,
  input  wire sprk_pkg::dp_status_t st,
  output      sprk_pkg::dp_op_t     op
);

  sprk_pkg::fsm_state_t state, state_next;

  assign req_ready = (state == sprk_pkg::ST_IDLE) && !st.out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sprk_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sprk_pkg::ST_CLEAR:     if (st.clr_last) state_next = sprk_pkg::ST_IDLE;
      sprk_pkg::ST_IDLE:      if (req_valid && req_ready) state_next = sprk_pkg::ST_DISPATCH;
      sprk_pkg::ST_DISPATCH: begin
        if (st.kind == sprk_pkg::REQ_CLEAR) begin
          state_next = sprk_pkg::ST_CLEAR_REQ;
        end else if (st.n_zero) begin
          state_next = sprk_pkg::ST_IDLE;
        end else begin
          case (st.kind)
            sprk_pkg::REQ_ADD:  state_next = (st.node_oor || st.full) ?
                                             sprk_pkg::ST_IDLE : sprk_pkg::ST_ADD_INC;
            sprk_pkg::REQ_RUN:  state_next = sprk_pkg::ST_SEED_DIV;
            sprk_pkg::REQ_READ: state_next = st.node_oor ?
                                             sprk_pkg::ST_IDLE : sprk_pkg::ST_READ_POST;
            default:            state_next = sprk_pkg::ST_IDLE;
          endcase
        end
      end
      sprk_pkg::ST_CLEAR_REQ:   if (st.clr_last) state_next = sprk_pkg::ST_POST_OK;
      sprk_pkg::ST_ADD_INC:     state_next = sprk_pkg::ST_IDLE;
      sprk_pkg::ST_READ_POST:   state_next = sprk_pkg::ST_IDLE;
      sprk_pkg::ST_POST_OK:     state_next = sprk_pkg::ST_IDLE;
      sprk_pkg::ST_SEED_DIV:    if (!st.div_busy) state_next = sprk_pkg::ST_SEED_WR;
      sprk_pkg::ST_SEED_WR:     if (st.idx_last) state_next = sprk_pkg::ST_ITER_CHK;
      sprk_pkg::ST_ITER_CHK:    state_next = st.iterate ? sprk_pkg::ST_SINK_RD :
                                                          sprk_pkg::ST_SUM_RD;
      sprk_pkg::ST_SINK_RD:     state_next = sprk_pkg::ST_SINK_ACC;
      sprk_pkg::ST_SINK_ACC:    state_next = st.idx_last ? sprk_pkg::ST_SHARE_MUL :
                                                           sprk_pkg::ST_SINK_RD;
      sprk_pkg::ST_SHARE_MUL:   state_next = sprk_pkg::ST_SHARE_START;
      sprk_pkg::ST_SHARE_START: state_next = sprk_pkg::ST_SHARE_DIV;
      sprk_pkg::ST_SHARE_DIV:   if (!st.div_busy) state_next = sprk_pkg::ST_INIT_WR;
      sprk_pkg::ST_INIT_WR:     if (st.idx_last) state_next = sprk_pkg::ST_EDGE_START;
      sprk_pkg::ST_EDGE_START:  state_next = st.edge_none ? sprk_pkg::ST_UPD_RD :
                                                            sprk_pkg::ST_EDGE_RD;
      sprk_pkg::ST_EDGE_RD:     state_next = sprk_pkg::ST_EDGE_NODE;
      sprk_pkg::ST_EDGE_NODE:   state_next = sprk_pkg::ST_EDGE_CHK;
      sprk_pkg::ST_EDGE_CHK:    state_next = st.edge_skip ? sprk_pkg::ST_EDGE_NEXT :
                                                            sprk_pkg::ST_EDGE_DIV;
      sprk_pkg::ST_EDGE_DIV:    if (!st.div_busy) state_next = sprk_pkg::ST_EDGE_MUL;
      sprk_pkg::ST_EDGE_MUL:    state_next = sprk_pkg::ST_EDGE_ACC;
      sprk_pkg::ST_EDGE_ACC:    state_next = sprk_pkg::ST_EDGE_NEXT;
      sprk_pkg::ST_EDGE_NEXT:   state_next = st.edge_last ? sprk_pkg::ST_UPD_RD :
                                                            sprk_pkg::ST_EDGE_RD;
      sprk_pkg::ST_UPD_RD:      state_next = sprk_pkg::ST_UPD_WR;
      sprk_pkg::ST_UPD_WR:      state_next = st.idx_last ? sprk_pkg::ST_ITER_CHK :
                                                           sprk_pkg::ST_UPD_RD;
      sprk_pkg::ST_SUM_RD:      state_next = sprk_pkg::ST_SUM_ACC;
      sprk_pkg::ST_SUM_ACC:     state_next = st.idx_last ? sprk_pkg::ST_NORM_CHK :
                                                           sprk_pkg::ST_SUM_RD;
      sprk_pkg::ST_NORM_CHK:    state_next = st.sum_zero ? sprk_pkg::ST_POST_OK :
                                                           sprk_pkg::ST_NORM_RD;
      sprk_pkg::ST_NORM_RD:     state_next = sprk_pkg::ST_NORM_START;
      sprk_pkg::ST_NORM_START:  state_next = sprk_pkg::ST_NORM_DIV;
      sprk_pkg::ST_NORM_DIV: begin
        if (!st.div_busy) begin
          state_next = st.idx_last ? sprk_pkg::ST_POST_OK : sprk_pkg::ST_NORM_RD;
        end
      end
      default:                  state_next = sprk_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op = sprk_pkg::OP_NONE;
    case (state)
      sprk_pkg::ST_CLEAR:     op = sprk_pkg::OP_CLR_WR;
      sprk_pkg::ST_DISPATCH: begin
        if (st.kind == sprk_pkg::REQ_CLEAR) begin
          op = sprk_pkg::OP_CLR_EDGES;
        end else if (st.n_zero) begin
          op = sprk_pkg::OP_POST_ERR;
        end else begin
          case (st.kind)
            sprk_pkg::REQ_ADD:  op = (st.node_oor || st.full) ?
                                     sprk_pkg::OP_POST_ERR : sprk_pkg::OP_ADD_WR;
            sprk_pkg::REQ_RUN:  op = sprk_pkg::OP_SEED_START;
            sprk_pkg::REQ_READ: op = st.node_oor ?
                                     sprk_pkg::OP_POST_ERR : sprk_pkg::OP_READ_RD;
            default:            op = sprk_pkg::OP_NONE;
          endcase
        end
      end
      sprk_pkg::ST_CLEAR_REQ:   op = sprk_pkg::OP_CLR_WR;
      sprk_pkg::ST_ADD_INC:     op = sprk_pkg::OP_ADD_INC;
      sprk_pkg::ST_READ_POST:   op = sprk_pkg::OP_POST_READ;
      sprk_pkg::ST_POST_OK:     op = sprk_pkg::OP_POST_OK;
      sprk_pkg::ST_SEED_WR:     op = sprk_pkg::OP_SEED_WR;
      sprk_pkg::ST_ITER_CHK:    op = st.iterate ? sprk_pkg::OP_SINK_CLR : sprk_pkg::OP_FINISH;
      sprk_pkg::ST_SINK_RD:     op = sprk_pkg::OP_SINK_RD;
      sprk_pkg::ST_SINK_ACC:    op = sprk_pkg::OP_SINK_ACC;
      sprk_pkg::ST_SHARE_MUL:   op = sprk_pkg::OP_SHARE_MUL;
      sprk_pkg::ST_SHARE_START: op = sprk_pkg::OP_SHARE_START;
      sprk_pkg::ST_INIT_WR:     op = sprk_pkg::OP_INIT_WR;
      sprk_pkg::ST_EDGE_RD:     op = sprk_pkg::OP_EDGE_RD;
      sprk_pkg::ST_EDGE_NODE:   op = sprk_pkg::OP_EDGE_NODE;
      sprk_pkg::ST_EDGE_CHK:    op = st.edge_skip ? sprk_pkg::OP_NONE :
                                                    sprk_pkg::OP_EDGE_DIV_START;
      sprk_pkg::ST_EDGE_MUL:    op = sprk_pkg::OP_EDGE_MUL;
      sprk_pkg::ST_EDGE_ACC:    op = sprk_pkg::OP_EDGE_ACC;
      sprk_pkg::ST_EDGE_NEXT:   op = sprk_pkg::OP_EDGE_NEXT;
      sprk_pkg::ST_UPD_RD:      op = sprk_pkg::OP_UPD_RD;
      sprk_pkg::ST_UPD_WR:      op = sprk_pkg::OP_UPD_WR;
      sprk_pkg::ST_SUM_RD:      op = sprk_pkg::OP_SUM_RD;
      sprk_pkg::ST_SUM_ACC:     op = sprk_pkg::OP_SUM_ACC;
      sprk_pkg::ST_NORM_RD:     op = sprk_pkg::OP_NORM_RD;
      sprk_pkg::ST_NORM_START:  op = sprk_pkg::OP_NORM_START;
      sprk_pkg::ST_NORM_DIV:    op = st.div_busy ? sprk_pkg::OP_NONE : sprk_pkg::OP_NORM_WR;
      default:                  op = sprk_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* src/sprk_dp.sv */
// ----------------------------------------------------------------------------
// sprk_dp
// Datapath: edge, degree and rank stores, counters, accumulators, divider,
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module sprk_dp #(
  parameter int MAX_NODES = 1024,
  parameter int MAX_EDGES = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire sprk_pkg::cfg_t       cfg,
  input  wire sprk_pkg::dp_op_t     op,
  output      sprk_pkg::dp_status_t st,
  input  wire logic                 req_accept,
  input  wire logic [1:0]           req_type,
  input  wire logic [9:0]           from_node,
  input  wire logic [9:0]           to_node,
  output      logic                 rsp_valid,
  input  wire logic                 rsp_ready,
  output      logic [1:0]           status,
  output      logic [31:0]          rank_value,
  output      logic [9:0]           iterations_used,
  output      logic                 converged
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int EAW = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int SW  = 32 + NAW;
  localparam int DVW = SW + 1;

  sprk_pkg::req_kind_t kind;
  logic [9:0]     from_q, to_q;
  logic [ETW-1:0] edge_total;
  logic [NAW-1:0] idx;
  logic [EAW-1:0] eidx;
  logic [9:0]     iter;
  logic [31:0]    worst;
  logic [SW-1:0]  sink;
  logic [SW-1:0]  sum;
  logic [SW+15:0] share_prod;
  logic [47:0]    part_prod;
  logic [9:0]     e_src, e_dst;
  logic [9:0]     last_iter;
  logic           last_conv;
  logic [1:0]     out_status;
  logic [31:0]    out_value;
  logic [10:0]    n;
  sprk_pkg::rsp_code_t err_code;

  logic           deg_we, deg_re;
  logic [NAW-1:0] deg_waddr, deg_raddr;
  logic [ETW-1:0] deg_wdata, deg_rdata;
  logic           rank_we, rank_re;
  logic [NAW-1:0] rank_waddr, rank_raddr;
  logic [31:0]    rank_wdata, rank_rdata;
  logic           acc_we, acc_re;
  logic [NAW-1:0] acc_waddr, acc_raddr;
  logic [31:0]    acc_wdata, acc_rdata;
  logic           edge_we, edge_re;
  logic [9:0]     esrc_rdata, edst_rdata;

  logic                          div_start, div_busy;
  logic [sprk_pkg::DIV_W-1:0]    div_dividend, div_q;
  logic [DVW-1:0]                div_divisor;
  logic [sprk_pkg::DIV_CW-1:0]   div_steps;
  logic [DVW-1:0]                share_num;
  logic [31:0]                   diff;

  assign n = ({21'd0, cfg.node_count} > 32'(MAX_NODES)) ? 11'(MAX_NODES) : cfg.node_count;

  assign share_num = DVW'(share_prod[SW+15:16])
                   + DVW'({17'h10000 - {1'b0, cfg.damping}, 15'd0});
  assign diff = (acc_rdata > rank_rdata) ? acc_rdata - rank_rdata : rank_rdata - acc_rdata;

  always_comb begin
    st.kind      = kind;
    st.n_zero    = (n == 11'd0);
    st.node_oor  = ({1'b0, from_q} >= n) ||
                   ((kind == sprk_pkg::REQ_ADD) && ({1'b0, to_q} >= n));
    st.full      = (32'(edge_total) == MAX_EDGES);
    st.div_busy  = div_busy;
    st.idx_last  = (32'(idx) == 32'(n) - 32'd1);
    st.clr_last  = (32'(idx) == MAX_NODES - 1);
    st.edge_none = (edge_total == '0);
    st.edge_last = (32'(eidx) == 32'(edge_total) - 32'd1);
    st.edge_skip = ({1'b0, e_src} >= n) || ({1'b0, e_dst} >= n) || (deg_rdata == '0);
    st.iterate   = (iter < cfg.iter_limit) && (worst >= cfg.conv_threshold);
    st.sum_zero  = (sum == '0);
    st.out_busy  = rsp_valid;
  end

  always_comb begin
    if (st.n_zero) begin
      err_code = sprk_pkg::RSP_EMPTY;
    end else if (st.node_oor) begin
      err_code = sprk_pkg::RSP_RANGE;
    end else if (st.full) begin
      err_code = sprk_pkg::RSP_FULL;
    end else begin
      err_code = sprk_pkg::RSP_OK;
    end
  end

  // store port and divider steering
  always_comb begin
    deg_we = 1'b0; deg_waddr = idx; deg_wdata = '0; deg_re = 1'b0; deg_raddr = idx;
    rank_we = 1'b0; rank_waddr = idx; rank_wdata = div_q[31:0];
    rank_re = 1'b0; rank_raddr = idx;
    acc_we = 1'b0; acc_waddr = idx; acc_wdata = sprk_pkg::sat32(div_q);
    acc_re = 1'b0; acc_raddr = idx;
    edge_we = 1'b0; edge_re = 1'b0;
    div_start = 1'b0; div_dividend = '0; div_divisor = DVW'(n);
    div_steps = sprk_pkg::DIV_STEPS_HALF;
    case (op)
      sprk_pkg::OP_CLR_WR: deg_we = 1'b1;
      sprk_pkg::OP_ADD_WR: begin
        edge_we   = 1'b1;
        deg_re    = 1'b1;
        deg_raddr = NAW'(from_q);
      end
      sprk_pkg::OP_ADD_INC: begin
        deg_we    = 1'b1;
        deg_waddr = NAW'(from_q);
        deg_wdata = ETW'(deg_rdata + 1'b1);
      end
      sprk_pkg::OP_READ_RD: begin
        rank_re    = 1'b1;
        rank_raddr = NAW'(from_q);
      end
      sprk_pkg::OP_SEED_START: begin
        div_start    = 1'b1;
        div_dividend = {sprk_pkg::RANK_ONE, 32'd0};
      end
      sprk_pkg::OP_SEED_WR: rank_we = 1'b1;
      sprk_pkg::OP_SINK_RD: begin
        rank_re = 1'b1;
        deg_re  = 1'b1;
      end
      sprk_pkg::OP_SHARE_START: begin
        div_start    = 1'b1;
        div_dividend = sprk_pkg::DIV_W'(share_num);
        div_steps    = sprk_pkg::DIV_STEPS_FULL;
      end
      sprk_pkg::OP_INIT_WR: acc_we = 1'b1;
      sprk_pkg::OP_EDGE_RD: edge_re = 1'b1;
      sprk_pkg::OP_EDGE_NODE: begin
        deg_re     = 1'b1;
        deg_raddr  = NAW'(esrc_rdata);
        rank_re    = 1'b1;
        rank_raddr = NAW'(esrc_rdata);
      end
      sprk_pkg::OP_EDGE_DIV_START: begin
        div_start    = 1'b1;
        div_dividend = {rank_rdata, 32'd0};
        div_divisor  = DVW'(deg_rdata);
      end
      sprk_pkg::OP_EDGE_MUL: begin
        acc_re    = 1'b1;
        acc_raddr = NAW'(e_dst);
      end
      sprk_pkg::OP_EDGE_ACC: begin
        acc_we    = 1'b1;
        acc_waddr = NAW'(e_dst);
        acc_wdata = sprk_pkg::sat32(64'(acc_rdata) + 64'(part_prod[47:16]));
      end
      sprk_pkg::OP_UPD_RD: begin
        acc_re  = 1'b1;
        rank_re = 1'b1;
      end
      sprk_pkg::OP_UPD_WR: begin
        rank_we    = 1'b1;
        rank_wdata = acc_rdata;
      end
      sprk_pkg::OP_SUM_RD, sprk_pkg::OP_NORM_RD: rank_re = 1'b1;
      sprk_pkg::OP_NORM_START: begin
        div_start    = 1'b1;
        div_dividend = {1'b0, rank_rdata, 31'd0};
        div_divisor  = DVW'(sum);
        div_steps    = sprk_pkg::DIV_STEPS_FULL;
      end
      sprk_pkg::OP_NORM_WR: begin
        rank_we    = 1'b1;
        rank_wdata = sprk_pkg::sat32(div_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kind       <= sprk_pkg::REQ_ADD;
      edge_total <= '0;
      idx        <= '0;
      eidx       <= '0;
      iter       <= '0;
      last_iter  <= '0;
      last_conv  <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (req_accept) begin
        kind   <= sprk_pkg::req_kind_t'(req_type);
        from_q <= from_node;
        to_q   <= to_node;
      end
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (op)
        sprk_pkg::OP_CLR_WR: idx <= st.clr_last ? '0 : NAW'(idx + 1'b1);
        sprk_pkg::OP_CLR_EDGES: edge_total <= '0;
        sprk_pkg::OP_POST_ERR: begin
          rsp_valid  <= 1'b1;
          out_status <= err_code;
          out_value  <= '0;
        end
        sprk_pkg::OP_ADD_WR: edge_total <= ETW'(edge_total + 1'b1);
        sprk_pkg::OP_ADD_INC, sprk_pkg::OP_POST_OK: begin
          rsp_valid  <= 1'b1;
          out_status <= sprk_pkg::RSP_OK;
          out_value  <= '0;
        end
        sprk_pkg::OP_POST_READ: begin
          rsp_valid  <= 1'b1;
          out_status <= sprk_pkg::RSP_OK;
          out_value  <= rank_rdata;
        end
        sprk_pkg::OP_SEED_START: begin
          iter  <= '0;
          worst <= sprk_pkg::RANK_ONE;
        end
        sprk_pkg::OP_SEED_WR, sprk_pkg::OP_INIT_WR, sprk_pkg::OP_NORM_WR:
          idx <= st.idx_last ? '0 : NAW'(idx + 1'b1);
        sprk_pkg::OP_SINK_CLR: sink <= '0;
        sprk_pkg::OP_FINISH: begin
          last_iter <= iter;
          last_conv <= (worst < cfg.conv_threshold);
          sum       <= '0;
        end
        sprk_pkg::OP_SINK_ACC: begin
          if (deg_rdata == '0) begin
            sink <= SW'(sink + SW'(rank_rdata));
          end
          idx <= st.idx_last ? '0 : NAW'(idx + 1'b1);
        end
        sprk_pkg::OP_SHARE_MUL: begin
          share_prod <= (SW+16)'(sink) * (SW+16)'(cfg.damping);
          worst      <= '0;
        end
        sprk_pkg::OP_EDGE_NODE: begin
          e_src <= esrc_rdata;
          e_dst <= edst_rdata;
        end
        sprk_pkg::OP_EDGE_MUL: part_prod <= 48'(div_q[31:0]) * 48'(cfg.damping);
        sprk_pkg::OP_EDGE_NEXT: eidx <= st.edge_last ? '0 : EAW'(eidx + 1'b1);
        sprk_pkg::OP_UPD_WR: begin
          if (diff > worst) begin
            worst <= diff;
          end
          idx <= st.idx_last ? '0 : NAW'(idx + 1'b1);
          if (st.idx_last) begin
            iter <= iter + 1'b1;
          end
        end
        sprk_pkg::OP_SUM_ACC: begin
          sum <= SW'(sum + SW'(rank_rdata));
          idx <= st.idx_last ? '0 : NAW'(idx + 1'b1);
        end
        default: ;
      endcase
    end
  end

  assign status          = out_status;
  assign rank_value      = out_value;
  assign iterations_used = last_iter;
  assign converged       = last_conv;

  sprk_ram #(.W(10), .D(MAX_EDGES)) u_edge_src (
    .clk(clk), .we(edge_we), .waddr(EAW'(edge_total)), .wdata(from_q),
    .re(edge_re), .raddr(eidx), .rdata(esrc_rdata)
  );

  sprk_ram #(.W(10), .D(MAX_EDGES)) u_edge_dst (
    .clk(clk), .we(edge_we), .waddr(EAW'(edge_total)), .wdata(to_q),
    .re(edge_re), .raddr(eidx), .rdata(edst_rdata)
  );

  sprk_ram #(.W(ETW), .D(MAX_NODES)) u_degree (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .re(deg_re), .raddr(deg_raddr), .rdata(deg_rdata)
  );

  sprk_ram #(.W(32), .D(MAX_NODES)) u_rank (
    .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .re(rank_re), .raddr(rank_raddr), .rdata(rank_rdata)
  );

  sprk_ram #(.W(32), .D(MAX_NODES)) u_acc (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
  );

  sprk_div #(.DVW(DVW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .steps(div_steps), .busy(div_busy), .quotient(div_q)
  );

endmodule

`default_nettype wire

/* verif/tb_sparse_pagerank_power_iteration.sv */
// ----------------------------------------------------------------------------
// tb_sparse_pagerank_power_iteration
// Self-checking bench for the sparse PageRank engine. Requests are driven from
// a queue; a cycle-free rank engine model predicts each reply on acceptance and
// the monitor compares every reply field in order. Registers go over APB
// between phases, only while the engine is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sparse_pagerank_power_iteration;

  localparam int NODES_MAX = 1024;
  localparam int EDGES_MAX = 4096;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    sprk_pkg::req_kind_t kind;
    logic [9:0]          from_node;
    logic [9:0]          to_node;
  } rank_req_t;

  typedef struct {
    sprk_pkg::rsp_code_t status;
    logic [31:0]         rank_value;
    logic [9:0]          iterations_used;
    logic                converged;
  } rank_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sprk_req_if req_ch();
  sprk_rsp_if rsp_ch();

  sparse_pagerank_power_iteration i_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  sprk_pkg::cfg_t cfg;
  logic [9:0]  edge_from[EDGES_MAX];
  logic [9:0]  edge_to[EDGES_MAX];
  int unsigned edge_cnt;
  int unsigned out_deg[NODES_MAX];
  logic [31:0] rank_cur[NODES_MAX];
  logic [9:0]  last_iters;
  logic        last_conv;

  rank_req_t   pending_reqs[$];
  rank_reply_t expected_replies[$];
  int          fail_count = 0;
  int          snd_idle_pct = 0;
  int          rcv_idle_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  logic        req_took = 1'b0;
  int unsigned cycle_cnt = 0;

  // generator-side bookkeeping
  int gen_nodes;
  int gen_edges;
  int gen_ranked;

  function automatic logic [31:0] sat_u32(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic void rank_power_run(int n);
    longint unsigned acc[NODES_MAX];
    longint unsigned worst, sink, share, part, total, d;
    logic [31:0] v, diff;
    int unsigned t;
    d = cfg.damping;
    t = 0;
    worst = 64'h8000_0000;
    total = 0;
    for (int i = 0; i < n; i++) rank_cur[i] = 32'(64'h8000_0000 / n);
    while (t < cfg.iter_limit && worst >= cfg.conv_threshold) begin
      sink = 0;
      for (int i = 0; i < n; i++)
        if (out_deg[i] == 0) sink += rank_cur[i];
      share = ((sink * d) >> 16) + ((65536 - d) << 15);
      share = share / n;
      for (int i = 0; i < n; i++) acc[i] = share;
      for (int e = 0; e < edge_cnt; e++) begin
        if (edge_from[e] >= n || edge_to[e] >= n || out_deg[edge_from[e]] == 0) continue;
        part = ((longint'(rank_cur[edge_from[e]] / out_deg[edge_from[e]])) * d) >> 16;
        acc[edge_to[e]] += part;
      end
      worst = 0;
      for (int i = 0; i < n; i++) begin
        v = sat_u32(acc[i]);
        diff = (v > rank_cur[i]) ? v - rank_cur[i] : rank_cur[i] - v;
        if (diff > worst) worst = diff;
        acc[i] = v;
      end
      for (int i = 0; i < n; i++) rank_cur[i] = acc[i][31:0];
      t++;
    end
    last_iters = t[9:0];
    last_conv = (worst < cfg.conv_threshold);
    for (int i = 0; i < n; i++) total += rank_cur[i];
    if (total != 0)
      for (int i = 0; i < n; i++)
        rank_cur[i] = sat_u32((longint'(rank_cur[i]) << 31) / total);
  endfunction

  function automatic rank_reply_t rank_predict(sprk_pkg::req_kind_t kind, logic [9:0] src,
                                               logic [9:0] dst);
    rank_reply_t r;
    int n;
    n = (cfg.node_count > NODES_MAX) ? NODES_MAX : cfg.node_count;
    r.status = sprk_pkg::RSP_OK;
    r.rank_value = '0;
    if (kind == sprk_pkg::REQ_CLEAR) begin
      edge_cnt = 0;
      for (int i = 0; i < NODES_MAX; i++) out_deg[i] = 0;
    end else if (n == 0) begin
      r.status = sprk_pkg::RSP_EMPTY;
    end else if (kind == sprk_pkg::REQ_ADD) begin
      if (src >= n || dst >= n) r.status = sprk_pkg::RSP_RANGE;
      else if (edge_cnt >= EDGES_MAX) r.status = sprk_pkg::RSP_FULL;
      else begin
        edge_from[edge_cnt] = src;
        edge_to[edge_cnt] = dst;
        edge_cnt++;
        out_deg[src]++;
      end
    end else if (kind == sprk_pkg::REQ_RUN) begin
      rank_power_run(n);
    end else begin
      if (src >= n) r.status = sprk_pkg::RSP_RANGE;
      else r.rank_value = rank_cur[src];
    end
    r.iterations_used = last_iters;
    r.converged = last_conv;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    rank_req_t it;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_took) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        it = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.req_type <= it.kind;
        req_ch.from_node <= it.from_node;
        req_ch.to_node <= it.to_node;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = sprk_pkg::REQ_ADD;
    req_ch.from_node = '0;
    req_ch.to_node = '0;
    rsp_ch.ready = 1'b0;
  end

  // receiver
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 300;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    rank_reply_t exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    req_took = req_ch.valid && req_ch.ready;
    if (!rst && req_took)
      expected_replies.insert(expected_replies.size(),
                              rank_predict(sprk_pkg::req_kind_t'(req_ch.req_type),
                                           req_ch.from_node, req_ch.to_node));
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_replies.size() == 0) begin
        $error("reply with nothing expected");
        fail_count++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (rsp_ch.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.rank_value !== exp_r.rank_value) begin
          $error("rank_value: expected %0h, got %0h", exp_r.rank_value, rsp_ch.rank_value);
          fail_count++;
        end
        if (rsp_ch.iterations_used !== exp_r.iterations_used) begin
          $error("iterations_used: expected %0d, got %0d", exp_r.iterations_used,
                 rsp_ch.iterations_used);
          fail_count++;
        end
        if (rsp_ch.converged !== exp_r.converged) begin
          $error("converged: expected %0d, got %0d", exp_r.converged, rsp_ch.converged);
          fail_count++;
        end
      end
    end
  end

  task automatic reg_write(sprk_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sprk_pkg::REG_NODE_COUNT:     cfg.node_count = value[10:0];
      sprk_pkg::REG_DAMPING:        cfg.damping = value[15:0];
      sprk_pkg::REG_CONV_THRESHOLD: cfg.conv_threshold = value;
      sprk_pkg::REG_ITER_LIMIT:     cfg.iter_limit = value[9:0];
      default: ;
    endcase
    if (idx == sprk_pkg::REG_NODE_COUNT)
      gen_nodes = (value[10:0] > NODES_MAX) ? NODES_MAX : value[10:0];
  endtask

  task automatic set_config(int nodes, int damp, logic [31:0] thr, int iters);
    reg_write(sprk_pkg::REG_NODE_COUNT, nodes);
    reg_write(sprk_pkg::REG_DAMPING, damp);
    reg_write(sprk_pkg::REG_CONV_THRESHOLD, thr);
    reg_write(sprk_pkg::REG_ITER_LIMIT, iters);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || req_ch.valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_req(sprk_pkg::req_kind_t kind, int src, int dst);
    rank_req_t it;
    it.kind = kind;
    it.from_node = 10'(src);
    it.to_node = 10'(dst);
    pending_reqs.insert(pending_reqs.size(), it);
    if (kind == sprk_pkg::REQ_CLEAR) gen_edges = 0;
    if (kind == sprk_pkg::REQ_ADD && src < gen_nodes && dst < gen_nodes) gen_edges++;
    if (kind == sprk_pkg::REQ_RUN && gen_nodes > gen_ranked) gen_ranked = gen_nodes;
  endtask

  task automatic gen_random(int count);
    int r, a;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (gen_edges >= 24)
        push_req(sprk_pkg::REQ_CLEAR, $urandom_range(1023), $urandom_range(1023));
      else if (r < 8) push_req(sprk_pkg::REQ_RUN, $urandom_range(1023), $urandom_range(1023));
      else if (r < 55)
        push_req(sprk_pkg::REQ_ADD, $urandom_range(gen_nodes - 1),
                 $urandom_range(gen_nodes - 1));
      else if (r < 60)
        push_req(sprk_pkg::REQ_ADD, $urandom_range(1023), $urandom_range(1023));
      else if (r < 93) begin
        a = $urandom_range(1023);
        if (r < 85 && gen_ranked > 0) a = $urandom_range(gen_ranked - 1);
        else if (a < gen_nodes && a >= gen_ranked) a = gen_nodes;
        push_req(sprk_pkg::REQ_READ, a, $urandom_range(1023));
      end else push_req(sprk_pkg::REQ_CLEAR, $urandom_range(1023), $urandom_range(1023));
    end
  endtask

  task automatic random_phase(int snd, int rcv, int count);
    logic [31:0] thr;
    int pick;
    wait_drained();
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
    pick = $urandom_range(4);
    case (pick)
      0: thr = 0;
      1: thr = $urandom_range(4000);
      2: thr = 32'h8000_0000;
      3: thr = 32'hFFFF_FFFF;
      default: thr = $urandom;
    endcase
    set_config($urandom_range(1, 24), $urandom_range(65535), thr, $urandom_range(1, 8));
    push_req(sprk_pkg::REQ_CLEAR, 0, 0);
    gen_random(count);
  endtask

  initial begin
    cfg.node_count = '0;
    cfg.damping = sprk_pkg::DAMPING_RESET;
    cfg.conv_threshold = sprk_pkg::THRESHOLD_RESET;
    cfg.iter_limit = sprk_pkg::MAX_ITER_RESET;
    edge_cnt = 0;
    for (int i = 0; i < NODES_MAX; i++) begin
      out_deg[i] = 0;
      rank_cur[i] = '0;
    end
    last_iters = '0;
    last_conv = 1'b0;
    gen_nodes = 0;
    gen_edges = 0;
    gen_ranked = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // no nodes configured
    push_req(sprk_pkg::REQ_ADD, 0, 0);
    push_req(sprk_pkg::REQ_RUN, 0, 0);
    push_req(sprk_pkg::REQ_READ, 0, 0);
    push_req(sprk_pkg::REQ_CLEAR, 0, 0);
    wait_drained();

    // small graph, default damping
    set_config(4, sprk_pkg::DAMPING_RESET, sprk_pkg::THRESHOLD_RESET, sprk_pkg::MAX_ITER_RESET);
    push_req(sprk_pkg::REQ_ADD, 0, 3);
    push_req(sprk_pkg::REQ_ADD, 3, 0);
    push_req(sprk_pkg::REQ_ADD, 1, 2);
    push_req(sprk_pkg::REQ_ADD, 0, 4);
    push_req(sprk_pkg::REQ_ADD, 1023, 1);
    push_req(sprk_pkg::REQ_READ, 1023, 0);
    push_req(sprk_pkg::REQ_RUN, 0, 0);
    for (int i = 0; i < 5; i++) push_req(sprk_pkg::REQ_READ, i, 0);
    push_req(sprk_pkg::REQ_CLEAR, 0, 0);
    push_req(sprk_pkg::REQ_RUN, 0, 0);
    push_req(sprk_pkg::REQ_READ, 2, 0);
    wait_drained();

    // iteration limit at its top, threshold zero never converges
    set_config(2, 65535, 0, 1023);
    push_req(sprk_pkg::REQ_ADD, 0, 1);
    push_req(sprk_pkg::REQ_RUN, 0, 0);
    push_req(sprk_pkg::REQ_READ, 1, 0);
    wait_drained();

    // full node range
    set_config(1024, 0, 0, 1);
    push_req(sprk_pkg::REQ_ADD, 1023, 0);
    push_req(sprk_pkg::REQ_ADD, 0, 1023);
    push_req(sprk_pkg::REQ_ADD, 682, 341);
    push_req(sprk_pkg::REQ_ADD, 341, 682);
    push_req(sprk_pkg::REQ_ADD, 1023, 1023);
    push_req(sprk_pkg::REQ_RUN, 0, 0);
    push_req(sprk_pkg::REQ_READ, 1023, 0);
    push_req(sprk_pkg::REQ_READ, 682, 0);
    push_req(sprk_pkg::REQ_READ, 341, 0);
    wait_drained();

    // shrunken node count, threshold above one
    set_config(3, 65535, 32'hFFFF_FFFF, 5);
    push_req(sprk_pkg::REQ_RUN, 0, 0);
    push_req(sprk_pkg::REQ_READ, 0, 0);
    push_req(sprk_pkg::REQ_READ, 3, 0);
    wait_drained();
    set_config(2047, 32768, 32'h8000_0000, 0);
    push_req(sprk_pkg::REQ_ADD, 1023, 5);
    push_req(sprk_pkg::REQ_READ, 1000, 0);
    push_req(sprk_pkg::REQ_CLEAR, 0, 0);
    wait_drained();

    random_phase(14, 74, 230);
    random_phase(74, 14, 230);
    wait_drained();
    hold_reqs = hold_reqs + 1;
    random_phase(0, 0, 240);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
